### rtl/core/svil_pkg.sv
// Shared constants and operation codes for the sorted vertex insert list.
package svil_pkg;

    // Fixed field widths of the item channels
    localparam int COORD_W   = 16;
    localparam int RD_IDX_W  = 6;
    localparam int CNT_OUT_W = 7;

    // Default sizing of the list
    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 16;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

endpackage

### rtl/core/svil_if.sv
// Handshake interfaces for the request and result channels of the vertex list.
interface svil_in_if;
    import svil_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [COORD_W-1:0]  page;
    logic [COORD_W-1:0]  x_pos;
    logic [COORD_W-1:0]  y_pos;
    logic [RD_IDX_W-1:0] read_index;

    modport source (
        output valid, operation, page, x_pos, y_pos, read_index,
        input  ready
    );
    modport sink (
        input  valid, operation, page, x_pos, y_pos, read_index,
        output ready
    );
endinterface

interface svil_out_if;
    import svil_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COORD_W-1:0]   out_page;
    logic [COORD_W-1:0]   out_x;
    logic [COORD_W-1:0]   out_y;
    logic                 entry_valid;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 dropped;

    modport source (
        output valid, out_page, out_x, out_y, entry_valid, entry_count, dropped,
        input  ready
    );
    modport sink (
        input  valid, out_page, out_x, out_y, entry_valid, entry_count, dropped,
        output ready
    );
endinterface

### rtl/core/svil_cell.sv
// One slot of the sorted list: holds a vertex, compares it with the new one and shifts down.
module svil_cell #(
    parameter int IDX   = 0,
    parameter int VTX_W = 48,
    parameter int CNT_W = 7
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [CNT_W-1:0] i_count,
    input  logic [VTX_W-1:0] i_vtx,
    input  logic             i_prev_after,
    input  logic [VTX_W-1:0] i_prev_vtx,
    output logic             o_after,
    output logic [VTX_W-1:0] o_vtx
);
    logic [VTX_W-1:0] r_vtx;
    logic [VTX_W-1:0] n_vtx;
    logic             occupied;
    logic             at_or_below;

    // Vertex is packed page, y, x from the top, so one unsigned compare orders it
    assign occupied    = CNT_W'(IDX) < i_count;
    assign at_or_below = r_vtx <= i_vtx;
    assign o_after     = !occupied || at_or_below;
    assign o_vtx       = r_vtx;

    // Take the neighbor's vertex past the insertion point, the new one at it
    always_comb begin
        if (i_prev_after) begin
            n_vtx = i_prev_vtx;
        end else if (o_after) begin
            n_vtx = i_vtx;
        end else begin
            n_vtx = r_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_vtx <= n_vtx;
        end
    end
endmodule

### rtl/core/sorted_vertex_insert_list.sv
// Top level of the sorted vertex insert list: cell row, count, read select and result register.
//
//  channel | dir | payload                                                     | handshake
//  i_in    | in  | operation, page, x_pos, y_pos, read_index                   | valid/ready
//  o_out   | out | out_page, out_x, out_y, entry_valid, entry_count, dropped   | valid/ready
//
// For every item the cell row compares the new vertex with all stored
// entries at once and shifts in the same edge; a read selects among the first 64 cells.
// One item is accepted per cycle while the result register is empty or being drained.
// Reset clears the count and the result valid; cell contents are left as they are.
// A stall on the output holds the result and blocks new items until it is taken.
module sorted_vertex_insert_list #(
    parameter int CAPACITY   = svil_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = svil_pkg::COORD_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    svil_in_if.sink   i_in,
    svil_out_if.source o_out
);
    import svil_pkg::*;

    localparam int VTX_W  = 3 * COORD_BITS;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RD_N   = 1 << RD_IDX_W;
    localparam int RD_CEL = (CAPACITY < RD_N) ? CAPACITY : RD_N;
    localparam int CMP_W  = (CNT_W > RD_IDX_W) ? CNT_W : RD_IDX_W;

    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_ovalid;
    logic [COORD_W-1:0]   r_page;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic                 r_evalid;
    logic [CNT_OUT_W-1:0] r_ecount;
    logic                 r_drop;

    logic             accept;
    logic             is_insert;
    logic             full;
    logic             we;
    logic             rd_hit;
    logic [VTX_W-1:0] new_vtx;
    logic [VTX_W-1:0] rd_vtx;
    logic [VTX_W-1:0] cell_vtx   [CAPACITY];
    logic             cell_after [CAPACITY];
    logic [VTX_W-1:0] rd_arr     [RD_N];

    // Handshake: accept whenever the result register is free this cycle
    assign i_in.ready = !r_ovalid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign is_insert  = i_in.operation == OP_INSERT;
    assign full       = r_count >= CNT_W'(CAPACITY);
    assign we         = accept && is_insert && !full;

    assign new_vtx = {COORD_BITS'(i_in.page), COORD_BITS'(i_in.y_pos), COORD_BITS'(i_in.x_pos)};

    // Row of cells, each passing its vertex and shift flag to the next one
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic             prev_after;
        logic [VTX_W-1:0] prev_vtx;
        if (g == 0) begin : g_head
            assign prev_after = 1'b0;
            assign prev_vtx   = '0;
        end else begin : g_link
            assign prev_after = cell_after[g-1];
            assign prev_vtx   = cell_vtx[g-1];
        end
        svil_cell #(
            .IDX   (g),
            .VTX_W (VTX_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_we         (we),
            .i_count      (r_count),
            .i_vtx        (new_vtx),
            .i_prev_after (prev_after),
            .i_prev_vtx   (prev_vtx),
            .o_after      (cell_after[g]),
            .o_vtx        (cell_vtx[g])
        );
    end

    // Read select over the cells the index can reach
    for (genvar k = 0; k < RD_N; k++) begin : g_rd
        if (k < RD_CEL) begin : g_use
            assign rd_arr[k] = cell_vtx[k];
        end else begin : g_pad
            assign rd_arr[k] = '0;
        end
    end
    assign rd_vtx = rd_arr[i_in.read_index];
    assign rd_hit = CMP_W'(i_in.read_index) < CMP_W'(r_count);

    // Count after this item
    always_comb begin
        if (we) begin
            n_count = r_count + CNT_W'(1);
        end else begin
            n_count = r_count;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ecount <= CNT_OUT_W'(n_count);
            if (!is_insert && rd_hit) begin
                r_page   <= COORD_W'(rd_vtx[3*COORD_BITS-1:2*COORD_BITS]);
                r_y      <= COORD_W'(rd_vtx[2*COORD_BITS-1:COORD_BITS]);
                r_x      <= COORD_W'(rd_vtx[COORD_BITS-1:0]);
                r_evalid <= 1'b1;
            end else begin
                r_page   <= '0;
                r_y      <= '0;
                r_x      <= '0;
                r_evalid <= 1'b0;
            end
            r_drop <= is_insert && full;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.out_page    = r_page;
    assign o_out.out_x       = r_x;
    assign o_out.out_y       = r_y;
    assign o_out.entry_valid = r_evalid;
    assign o_out.entry_count = r_ecount;
    assign o_out.dropped     = r_drop;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("count exceeds capacity");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_insert && full |=> r_count == $past(r_count) && r_drop)
        else $error("insert into full list changed count or was not flagged");

    a_insert_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && is_insert && !full |=> r_count == $past(r_count) + CNT_W'(1) && !r_drop)
        else $error("accepted insert did not grow the list by one");

    a_read_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !is_insert |=> r_ovalid && !r_drop && r_count == $past(r_count))
        else $error("read changed count or flagged a drop");
`endif
endmodule

### dv/sorted_vertex_insert_list_test.sv
// Self-checking testbench for the sorted vertex insert list: random and directed items.
module sorted_vertex_insert_list_test;
    import svil_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 100;
    localparam int DRAIN_WAIT  = 20;
    localparam int MAX_REPORTS = 10;

    // Vertex ordered as one number: page, then y, then x
    typedef struct packed {
        logic [COORD_W-1:0] page;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_vertex;

    typedef struct packed {
        logic                operation;
        logic [COORD_W-1:0]  page;
        logic [COORD_W-1:0]  x_pos;
        logic [COORD_W-1:0]  y_pos;
        logic [RD_IDX_W-1:0] read_index;
    } t_vertex_req;

    typedef struct packed {
        logic [COORD_W-1:0]   out_page;
        logic [COORD_W-1:0]   out_x;
        logic [COORD_W-1:0]   out_y;
        logic                 entry_valid;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 dropped;
    } t_list_result;

    logic i_clk;
    logic i_rst_n;

    svil_in_if  in_bus ();
    svil_out_if out_bus ();

    sorted_vertex_insert_list #(
        .CAPACITY   (CAPACITY_DEF),
        .COORD_BITS (COORD_BITS_DEF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    t_vertex_req  pending_requests[$];
    t_list_result expected_results[$];
    t_vertex      sorted_shadow[$];
    t_vertex_req  offered_req;

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int planned_count = 0;
    int fail_count    = 0;
    int cycle_count   = 0;
    int hold_left;
    logic hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Known values on every input from time zero
    initial begin
        i_rst_n            = 1'b0;
        hold_req           = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.operation   = OP_INSERT;
        in_bus.page        = '0;
        in_bus.x_pos       = '0;
        in_bus.y_pos       = '0;
        in_bus.read_index  = '0;
        out_bus.ready      = 1'b0;
    end

    // Apply one accepted item to the shadow list and return its result
    function automatic t_list_result predict_list_result(t_vertex_req req);
        t_list_result res;
        t_vertex      v;
        int           pos;
        res = '0;
        if (req.operation == OP_INSERT) begin
            if (sorted_shadow.size() >= CAPACITY_DEF) begin
                res.dropped = 1'b1;
            end else begin
                v   = '{page: req.page, y: req.y_pos, x: req.x_pos};
                pos = 0;
                // new vertex goes ahead of the first entry at or below it
                while (pos < sorted_shadow.size() && sorted_shadow[pos] > v)
                    pos++;
                sorted_shadow.insert(pos, v);
            end
        end else if (int'(req.read_index) < sorted_shadow.size()) begin
            res.out_page    = sorted_shadow[req.read_index].page;
            res.out_x       = sorted_shadow[req.read_index].x;
            res.out_y       = sorted_shadow[req.read_index].y;
            res.entry_valid = 1'b1;
        end
        res.entry_count = CNT_OUT_W'(sorted_shadow.size());
        return res;
    endfunction

    // Coordinates biased toward extremes and small values so ties are common
    function automatic logic [COORD_W-1:0] rand_coord();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return COORD_W'($urandom_range(3));
            default: return COORD_W'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_vertex_req make_vertex_req(logic op, logic [COORD_W-1:0] page,
                                                    logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y, int idx);
        t_vertex_req req;
        req.operation  = op;
        req.page       = page;
        req.x_pos      = x;
        req.y_pos      = y;
        req.read_index = RD_IDX_W'(idx);
        if (op == OP_INSERT && planned_count < CAPACITY_DEF)
            planned_count++;
        return req;
    endfunction

    // Mostly reads aimed inside the list, with inserts filling it over the run
    function automatic t_vertex_req make_random_request();
        int idx;
        int pick;
        if ($urandom_range(99) < 35)
            return make_vertex_req(OP_INSERT, rand_coord(), rand_coord(), rand_coord(),
                                   $urandom_range(63));
        pick = $urandom_range(99);
        if (planned_count == 0 || pick < 15)
            idx = $urandom_range(63);
        else if (pick < 25)
            idx = 0;
        else if (pick < 40)
            idx = planned_count - 1;
        else
            idx = $urandom_range(planned_count - 1);
        return make_vertex_req(OP_READ, rand_coord(), rand_coord(), rand_coord(), idx);
    endfunction

    // Driver: advance to the next item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
        end else begin
            if (in_bus.valid && in_bus.ready)
                expected_results.push_back(predict_list_result(offered_req));
            if (!in_bus.valid || in_bus.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered_req        = pending_requests.pop_front();
                    in_bus.operation  <= offered_req.operation;
                    in_bus.page       <= offered_req.page;
                    in_bus.x_pos      <= offered_req.x_pos;
                    in_bus.y_pos      <= offered_req.y_pos;
                    in_bus.read_index <= offered_req.read_index;
                    in_bus.valid      <= 1'b1;
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        t_list_result got;
        t_list_result want;
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                got = '{out_page: out_bus.out_page, out_x: out_bus.out_x,
                        out_y: out_bus.out_y, entry_valid: out_bus.entry_valid,
                        entry_count: out_bus.entry_count, dropped: out_bus.dropped};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result: page=%h x=%h y=%h valid=%b count=%0d drop=%b",
                                 got.out_page, got.out_x, got.out_y, got.entry_valid,
                                 got.entry_count, got.dropped);
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_page !== want.out_page || got.out_x !== want.out_x ||
                        got.out_y !== want.out_y || got.entry_valid !== want.entry_valid ||
                        got.entry_count !== want.entry_count ||
                        got.dropped !== want.dropped) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("mismatch at cycle %0d", cycle_count);
                            $display("  expected page=%h x=%h y=%h valid=%b count=%0d drop=%b",
                                     want.out_page, want.out_x, want.out_y,
                                     want.entry_valid, want.entry_count, want.dropped);
                            $display("  actual   page=%h x=%h y=%h valid=%b count=%0d drop=%b",
                                     got.out_page, got.out_x, got.out_y,
                                     got.entry_valid, got.entry_count, got.dropped);
                        end
                    end
                end
            end
            out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Hold the sender until every expected result has come back
    task automatic drain_list();
        while (pending_requests.size() != 0 || in_bus.valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_random_phase(int idle_pct, int stall_pct, bit with_hold);
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        if (with_hold) begin
            @(posedge i_clk);
            hold_req <= 1'b1;
            @(posedge i_clk);
            hold_req <= 1'b0;
        end
        repeat (PHASE_ITEMS)
            pending_requests.push_back(make_random_request());
        drain_list();
    endtask

    // Stimulus and end of run
    initial begin
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty reads, extremes, ties on page and y, front and back
        pending_requests.push_back(make_vertex_req(OP_READ, '0, '0, '0, 0));
        pending_requests.push_back(make_vertex_req(OP_READ, '1, '1, '1, 63));
        pending_requests.push_back(make_vertex_req(OP_INSERT, '0, '0, '0, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, '1, '1, '1, 63));
        pending_requests.push_back(make_vertex_req(OP_INSERT, '0, '0, '0, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd5, 16'd1, 16'd7, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd5, 16'd2, 16'd7, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd5, 16'hFFFF, 16'd6, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd5, 16'd0, 16'd8, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd6, 16'd0, 16'd0, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, 16'd4, '1, '1, 0));
        pending_requests.push_back(make_vertex_req(OP_INSERT, '1, '1, '1, 0));
        for (int i = 0; i <= planned_count; i++)
            pending_requests.push_back(make_vertex_req(OP_READ, '1, '0, '1, i));
        pending_requests.push_back(make_vertex_req(OP_READ, '0, '1, '0, 63));
        drain_list();

        // Random phases: clean, sender gaps, receiver stalls with long hold, both
        run_random_phase(0, 0, 1'b0);
        run_random_phase(60, 0, 1'b0);
        run_random_phase(0, 60, 1'b1);
        run_random_phase(14, 14, 1'b0);

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### sorted_vertex_insert_list.f
rtl/core/svil_pkg.sv
rtl/core/svil_if.sv
rtl/core/svil_cell.sv
rtl/core/sorted_vertex_insert_list.sv
dv/sorted_vertex_insert_list_test.sv
